// ===== hw/rtl/tkr_pkg.sv =====
// ----------------------------------------------------------------------------
// tkr_pkg: shared types and constants of the top-K rank insertion sorter
// Holds the transaction payload types, the mode codes and the default depth.
// ----------------------------------------------------------------------------
package tkr_pkg;

  localparam int KEEP_COUNT_DEF = 10;
  localparam int SCORE_W        = 32;
  localparam int ID_W           = 32;
  localparam int MODE_W         = 2;
  localparam int SLOT_W         = 4;

  localparam logic [MODE_W-1:0] MODE_OFFER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [SCORE_W-1:0] score;
    logic [ID_W-1:0]    doc_id;
  } req_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score_res;
    logic [ID_W-1:0]    doc_id_res;
    logic [SLOT_W-1:0]  slot;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [ID_W-1:0]    doc_id;
  } entry_t;

endpackage

// ===== hw/rtl/tkr_req_if.sv =====
// ----------------------------------------------------------------------------
// tkr_req_if: request channel of the top-K rank insertion sorter
// Carries valid, ready and one request payload per transaction.
// ----------------------------------------------------------------------------
interface tkr_req_if;
  logic          valid;
  logic          ready;
  tkr_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tkr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tkr_rsp_if: result channel of the top-K rank insertion sorter
// Carries valid, ready and one read-out entry per transaction.
// ----------------------------------------------------------------------------
interface tkr_rsp_if;
  logic          valid;
  logic          ready;
  tkr_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/top_k_rank_insertion.sv =====
// ----------------------------------------------------------------------------
// top_k_rank_insertion: top-K insertion sorter
// Keeps the KEEP_COUNT best scored documents in descending order, with
// offer, clear and full read-out requests.
// ----------------------------------------------------------------------------
//   Channel  Direction  Payload                               Handshake
//   req      in         mode, score, doc_id                   valid/ready
//   rsp      out        score_res, doc_id_res, slot, last     valid/ready
//
// Offer and clear requests are accepted every cycle while no read-out is busy.
// A read-out request emits KEEP_COUNT transactions, one per cycle while rsp
// is taken; the store rotates by one entry per emitted result, and req
// stays not ready until the last entry has been loaded into the output
// register. A stall on rsp holds the output register and pauses the read-out.
// Reset clears the store to zero scores and ids and empties the output.
// ----------------------------------------------------------------------------
module top_k_rank_insertion #(
  parameter int KEEP_COUNT = tkr_pkg::KEEP_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst,
  tkr_req_if.sink  req,
  tkr_rsp_if.source rsp
);

  localparam int CNT_W = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(KEEP_COUNT - 1);

  tkr_pkg::entry_t store [KEEP_COUNT];
  tkr_pkg::entry_t store_next [KEEP_COUNT];
  logic [KEEP_COUNT-1:0] above;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic             out_valid;
  tkr_pkg::rsp_t    out_data;

  logic             req_take;
  logic             load;
  logic [CNT_W+3:0] slot_wide;

  assign req.ready = !busy;
  assign req_take  = req.valid && !busy;
  assign load      = busy && (!out_valid || rsp.ready);
  assign slot_wide = {4'b0000, cnt};

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_comb begin
    for (int i = 0; i < KEEP_COUNT; i++) begin
      above[i] = req.data.score > store[i].score;
    end
    for (int i = 0; i < KEEP_COUNT; i++) begin
      store_next[i] = store[i];
    end
    if (load) begin
      for (int i = 0; i < KEEP_COUNT; i++) begin
        store_next[i] = store[(i + 1) % KEEP_COUNT];
      end
    end else if (req_take && req.data.mode == tkr_pkg::MODE_CLEAR) begin
      for (int i = 0; i < KEEP_COUNT; i++) begin
        store_next[i] = '0;
      end
    end else if (req_take && req.data.mode == tkr_pkg::MODE_OFFER && above[KEEP_COUNT-1]) begin
      for (int i = 0; i < KEEP_COUNT; i++) begin
        if (above[i]) begin
          if (i > 0 && above[(i > 0) ? i - 1 : 0]) begin
            store_next[i] = store[(i > 0) ? i - 1 : 0];
          end else begin
            store_next[i].score  = req.data.score;
            store_next[i].doc_id = req.data.doc_id;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEEP_COUNT; i++) begin
        store[i] <= '0;
      end
    end else begin
      for (int i = 0; i < KEEP_COUNT; i++) begin
        store[i] <= store_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          cnt  <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end else begin
        if (rsp.ready) begin
          out_valid <= 1'b0;
        end
        if (req_take && req.data.mode == tkr_pkg::MODE_READ) begin
          busy <= 1'b1;
          cnt  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.score_res  <= store[0].score;
      out_data.doc_id_res <= store[0].doc_id;
      out_data.slot       <= slot_wide[3:0];
      out_data.last       <= (cnt == CNT_LAST);
    end
  end

endmodule

// ===== hw/rtl/tkr_checker.sv =====
// ----------------------------------------------------------------------------
// tkr_checker: port-level checks of the top-K rank insertion sorter
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module tkr_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input tkr_pkg::req_t req_data,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input tkr_pkg::rsp_t rsp_data
);

  // A stalled result transaction holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("rsp payload changed while stalled");

  // An accepted read-out request blocks further requests.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_data.mode == tkr_pkg::MODE_READ |=> !req_ready)
    else $error("req ready right after a read-out request");

  // Within a read-out the next entry follows a taken one at once.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && !rsp_data.last |=> rsp_valid)
    else $error("gap inside a read-out");

  // Requests wait while a read-out is still in progress.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.last |-> !req_ready)
    else $error("req ready during a read-out");

endmodule

bind top_k_rank_insertion tkr_checker u_tkr_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_data  (req.data),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
